// ===== hdl/vlp_pkg.sv =====
// Shared types and constants of the vector literal parser.
package vlp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_INT   = 2'd0;
   localparam logic [1:0] KIND_FIX   = 2'd1;
   localparam logic [1:0] KIND_BOOL  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_UNEXPECTED = 2'd1;
   localparam logic [1:0] STATUS_UNTERM     = 2'd2;
   localparam logic [1:0] STATUS_BAD_BOOL   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_TRUE_WORD  = 1'b0;
   localparam logic CSR_FALSE_WORD = 1'b1;

   localparam int WORD_BITS  = 64;
   localparam int OUT_COUNT_BITS = 16;
   localparam int RSP_DATA_BITS = 88;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef struct packed {
      logic [WORD_BITS-1:0]      value;
      logic [1:0]                kind;
      logic [OUT_COUNT_BITS-1:0] element_count;
      logic [1:0]                status;
      logic                      last;
   } result_type;

   // Up to two results leave the parser per byte; second only with first.
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

// ===== hdl/vlp_core.sv =====
// Parser state machine: one text byte in, up to two results out.
module vlp_core #(
   parameter int COUNT_BITS    = 16,
   parameter int FRACTION_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 step,
   input  logic [7:0]           text_byte,
   output vlp_pkg::push_type    push
);
   import vlp_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_PAREN  = 3'd1;
   localparam logic [2:0] PH_OPEN   = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   localparam logic [1:0] MODE_INT  = 2'd0;
   localparam logic [1:0] MODE_FIX  = 2'd1;
   localparam logic [1:0] MODE_BOOL = 2'd2;

   localparam logic [1:0] RADIX_TEN     = 2'd0;
   localparam logic [1:0] RADIX_TWO     = 2'd1;
   localparam logic [1:0] RADIX_SIXTEEN = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [FRACTION_BITS-1:0] WEIGHT_TEN =
      FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd10);
   localparam logic [FRACTION_BITS-1:0] WEIGHT_TWO =
      FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd2);
   localparam logic [FRACTION_BITS-1:0] WEIGHT_SIXTEEN =
      FRACTION_BITS'((64'd1 << FRACTION_BITS) / 64'd16);
   // floor(w / 10) = (w * RECIP_TEN) >> (FRACTION_BITS + 3) for every w.
   localparam logic [FRACTION_BITS-1:0] RECIP_TEN =
      FRACTION_BITS'(((64'd1 << (FRACTION_BITS + 3)) + 64'd9) / 64'd10);

   logic [63:0]              true_word_ff, false_word_ff;
   logic [2:0]               phase_ff, phase_in;
   logic [1:0]               mode_ff, mode_in;
   logic [63:0]              acc_ff, acc_in;
   logic [FRACTION_BITS-1:0] weight_ff, weight_in;
   logic                     frac_ff, frac_in;
   logic [1:0]               radix_ff, radix_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   logic [3:0]                 digit;
   logic                       is_hex;
   logic [4:0]                 radix_val;
   logic                       digit_ok;
   logic [63:0]                acc_scaled;
   logic [FRACTION_BITS+3:0]   frac_prod;
   logic [2*FRACTION_BITS-1:0] recip_prod;
   logic [FRACTION_BITS-1:0]   weight_next;
   logic [FRACTION_BITS-1:0]   weight_start;
   logic [31:0]                count_wide;

   logic       finish, do_between, other_valid;
   result_type other_res, elem_res;
   logic [COUNT_BITS-1:0] count_mid;

   // Hex digit decode, limited to the current radix.
   always_comb begin
      digit  = 4'd0;
      is_hex = 1'b1;
      if (text_byte >= "0" && text_byte <= "9") begin
         digit = 4'(text_byte - "0");
      end else if (text_byte >= "a" && text_byte <= "f") begin
         digit = 4'(text_byte - "a" + 8'd10);
      end else if (text_byte >= "A" && text_byte <= "F") begin
         digit = 4'(text_byte - "A" + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      case (radix_ff)
         RADIX_TWO: begin
            radix_val    = 5'd2;
            acc_scaled   = acc_ff << 1;
            weight_next  = weight_ff >> 1;
            weight_start = WEIGHT_TWO;
         end
         RADIX_SIXTEEN: begin
            radix_val    = 5'd16;
            acc_scaled   = acc_ff << 4;
            weight_next  = weight_ff >> 4;
            weight_start = WEIGHT_SIXTEEN;
         end
         default: begin
            radix_val    = 5'd10;
            acc_scaled   = (acc_ff << 3) + (acc_ff << 1);
            weight_next  = FRACTION_BITS'(recip_prod >> (FRACTION_BITS + 3));
            weight_start = WEIGHT_TEN;
         end
      endcase
   end

   assign digit_ok   = is_hex && ({1'b0, digit} < radix_val);
   assign frac_prod  = (FRACTION_BITS+4)'(digit) * (FRACTION_BITS+4)'(weight_ff);
   assign recip_prod = (2*FRACTION_BITS)'(weight_ff) * (2*FRACTION_BITS)'(RECIP_TEN);
   assign count_wide = 32'(count_mid);

   always_comb begin
      phase_in    = phase_ff;
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      weight_in   = weight_ff;
      frac_in     = frac_ff;
      radix_in    = radix_ff;
      finish      = 1'b0;
      do_between  = 1'b0;
      other_valid = 1'b0;
      other_res   = '0;
      elem_res    = '0;
      count_mid   = count_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (text_byte == 8'd0 || text_byte inside {8'h20, [8'h09:8'h0D]}) begin
            end else if (text_byte == "i") begin
               mode_in  = MODE_INT;
               phase_in = PH_PAREN;
            end else if (text_byte == "f") begin
               mode_in  = MODE_FIX;
               phase_in = PH_PAREN;
            end else if (text_byte == "b") begin
               mode_in  = MODE_BOOL;
               phase_in = PH_PAREN;
            end else if (text_byte == "(") begin
               mode_in   = MODE_INT;
               count_mid = '0;
               phase_in  = PH_OPEN;
            end else begin
               other_valid             = 1'b1;
               other_res.kind          = KIND_END;
               other_res.element_count = count_wide[15:0];
               other_res.status        = STATUS_UNEXPECTED;
               phase_in                = PH_IDLE;
            end
         end
         PH_PAREN: begin
            if (text_byte == "(") begin
               count_mid = '0;
               phase_in  = PH_OPEN;
            end else begin
               other_valid             = 1'b1;
               other_res.kind          = KIND_END;
               other_res.element_count = count_wide[15:0];
               other_res.status        = (text_byte == 8'd0) ? STATUS_UNTERM : STATUS_UNEXPECTED;
               phase_in                = PH_IDLE;
            end
         end
         PH_OPEN: begin
            do_between = 1'b1;
         end
         PH_ZERO: begin
            if (text_byte == "x" || text_byte == "X") begin
               radix_in = RADIX_SIXTEEN;
               phase_in = PH_DIGITS;
            end else if (text_byte == "b" || text_byte == "B") begin
               radix_in = RADIX_TWO;
               phase_in = PH_DIGITS;
            end else begin
               finish = 1'b1;
            end
         end
         PH_DIGITS: begin
            if (digit_ok) begin
               if (mode_ff == MODE_INT) begin
                  acc_in = acc_scaled + 64'(digit);
               end else if (frac_ff) begin
                  acc_in    = acc_ff + 64'(frac_prod);
                  weight_in = weight_next;
               end else begin
                  acc_in = acc_scaled + (64'(digit) << FRACTION_BITS);
               end
            end else if (text_byte == "." && mode_ff == MODE_FIX) begin
               if (!frac_ff) begin
                  frac_in   = 1'b1;
                  weight_in = weight_start;
               end
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // A finished number is emitted, then the ending byte is handled anew.
      if (finish) begin
         elem_res.value = acc_ff;
         elem_res.kind  = (mode_ff == MODE_FIX) ? KIND_FIX : KIND_INT;
         do_between     = 1'b1;
         if (count_ff != COUNT_MAX) begin
            count_mid = count_ff + 1'b1;
         end
      end

      count_in = count_mid;

      if (do_between) begin
         phase_in = PH_OPEN;
         if (text_byte inside {8'h20, [8'h09:8'h0D]}) begin
         end else if (text_byte == ")") begin
            other_valid             = 1'b1;
            other_res.kind          = KIND_END;
            other_res.element_count = count_wide[15:0];
            phase_in                = PH_IDLE;
         end else if (text_byte == 8'd0) begin
            other_valid             = 1'b1;
            other_res.kind          = KIND_END;
            other_res.element_count = count_wide[15:0];
            other_res.status        = STATUS_UNTERM;
            phase_in                = PH_IDLE;
         end else if (mode_ff == MODE_BOOL) begin
            other_valid = 1'b1;
            if (text_byte == "T" || text_byte == "F") begin
               other_res.value = (text_byte == "T") ? true_word_ff : false_word_ff;
               other_res.kind  = KIND_BOOL;
               if (count_mid != COUNT_MAX) begin
                  count_in = count_mid + 1'b1;
               end
            end else begin
               other_res.kind          = KIND_END;
               other_res.element_count = count_wide[15:0];
               other_res.status        = STATUS_BAD_BOOL;
               phase_in                = PH_IDLE;
            end
         end else begin
            acc_in    = '0;
            weight_in = '0;
            frac_in   = 1'b0;
            radix_in  = RADIX_TEN;
            if (text_byte == "0") begin
               phase_in = PH_ZERO;
            end else if (text_byte >= "1" && text_byte <= "9") begin
               acc_in   = (mode_ff == MODE_INT) ? 64'(digit) : (64'(digit) << FRACTION_BITS);
               phase_in = PH_DIGITS;
            end else if (text_byte == "." && mode_ff == MODE_FIX) begin
               frac_in   = 1'b1;
               weight_in = WEIGHT_TEN;
               phase_in  = PH_DIGITS;
            end else begin
               other_valid             = 1'b1;
               other_res.kind          = KIND_END;
               other_res.element_count = count_wide[15:0];
               other_res.status        = STATUS_UNEXPECTED;
               phase_in                = PH_IDLE;
            end
         end
      end
   end

   always_comb begin
      push = '0;
      if (step) begin
         if (finish) begin
            push.valid0    = 1'b1;
            push.res0      = elem_res;
            push.res0.last = !other_valid;
            push.valid1    = other_valid;
            push.res1      = other_res;
            push.res1.last = 1'b1;
         end else begin
            push.valid0    = other_valid;
            push.res0      = other_res;
            push.res0.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         true_word_ff  <= 64'd1;
         false_word_ff <= 64'd0;
         phase_ff      <= PH_IDLE;
         mode_ff       <= MODE_INT;
         acc_ff        <= '0;
         weight_ff     <= '0;
         frac_ff       <= 1'b0;
         radix_ff      <= RADIX_TEN;
         count_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TRUE_WORD:  true_word_ff  <= csr_wdata;
               CSR_FALSE_WORD: false_word_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (step) begin
            phase_ff  <= phase_in;
            mode_ff   <= mode_in;
            acc_ff    <= acc_in;
            weight_ff <= weight_in;
            frac_ff   <= frac_in;
            radix_ff  <= radix_in;
            count_ff  <= count_in;
         end
      end
   end

endmodule

// ===== hdl/vlp_queue.sv =====
// Four-entry result queue that takes up to two results per cycle.
module vlp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  vlp_pkg::push_type    push,
   input  logic                 pop,
   output vlp_pkg::result_type  head,
   output logic                 head_valid,
   output logic                 has_room
);
   import vlp_pkg::*;

   result_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wptr_ff, rptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] push_num;

   assign push_num   = QUEUE_CNT_BITS'(push.valid0) + QUEUE_CNT_BITS'(push.valid1);
   assign head       = mem[rptr_ff];
   assign head_valid = (count_ff != '0);
   // Room for the worst case of two results from the next byte.
   assign has_room   = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem[wptr_ff] <= push.res0;
      end
      if (push.valid1) begin
         mem[wptr_ff + 1'b1] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_ff + QUEUE_PTR_BITS'(push_num);
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         count_ff <= count_ff + push_num - QUEUE_CNT_BITS'(pop);
      end
   end

endmodule

// ===== hdl/vector_literal_parser.sv =====
// Top level of the vector literal parser: input register, parser and result queue.
// Results of a byte pass the input register and then the result queue before they show on the result port.
// Throughput: one byte per cycle; a held byte goes to the parser only while the result queue
// has room for two results, so bytes giving two results can slow the input.
// Reset clears the parser to idle, empties the queue and sets true_word to 1
// and false_word to 0.
module vector_literal_parser #(
   parameter int COUNT_BITS    = 16,
   parameter int FRACTION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [63:0] value, [79:64] element_count,
                                    // [81:80] status, [87:82] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import vlp_pkg::*;

   logic [7:0]  byte_ff;
   logic        full_ff;
   logic        step;
   logic        has_room;
   logic        head_valid;
   push_type    push;
   result_type  head;

   assign step       = full_ff && has_room;
   assign req_tready = !full_ff || step;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         full_ff <= 1'b1;
      end else if (step) begin
         full_ff <= 1'b0;
      end
   end

   vlp_core #(
      .COUNT_BITS    (COUNT_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .text_byte (byte_ff),
      .push      (push)
   );

   vlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .has_room   (has_room)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {6'd0, head.status, head.element_count, head.value};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule

// ===== hdl/vlp_checker.sv =====
// Port-level checks of the vector literal parser, bound to the top level.
module vlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_we,
   input logic        csr_index,
   input logic [63:0] csr_wdata
);
   import vlp_pkg::*;

   // A result that is held back keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // After reset no result is pending and a byte can be taken.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not empty after reset");

   // Element results carry no count and always report success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_END |->
         rsp_tdata[79:64] == 16'd0 && rsp_tdata[81:80] == STATUS_OK)
      else $error("element result with count or error status");

   // End markers and errors carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tdata[63:0] == 64'd0)
      else $error("end marker with nonzero value");

   // End markers and errors are always the last result of their byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast)
      else $error("end marker not marked last");

endmodule

bind vector_literal_parser vlp_checker u_vlp_checker (.*);
